@@ design/sfd_pkg.sv @@
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and the CRC-8 step function for the stuffed
// frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

	// payload counter width
	localparam int COUNT_BITS = 16;

	// result queue depth between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// framing bytes
	localparam logic [7:0] BYTE_HEAD     = 8'h55;
	localparam logic [7:0] BYTE_TAIL     = 8'hAA;
	localparam logic [7:0] BYTE_ESC      = 8'hCC;
	localparam logic [7:0] ESC_CODE_HEAD = 8'h05;
	localparam logic [7:0] ESC_CODE_TAIL = 8'h0A;
	localparam logic [7:0] ESC_CODE_ESC  = 8'h0C;

	// configuration reset values
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd10240;
	localparam logic [7:0]  CRC_POLY_RST    = 8'h07;
	localparam logic [7:0]  CRC_INIT_RST    = 8'h00;
	localparam logic        CRC_REFLECT_RST = 1'b0;
	localparam logic [7:0]  CRC_XOROUT_RST  = 8'h00;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MAX_PAYLOAD = 3'd0,
		REG_CRC_POLY    = 3'd1,
		REG_CRC_INIT    = 3'd2,
		REG_CRC_REFLECT = 3'd3,
		REG_CRC_XOROUT  = 3'd4
	} sfd_reg_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_START    = 3'd0,
		KIND_DATA     = 3'd1,
		KIND_GOOD     = 3'd2,
		KIND_CRCERR   = 3'd3,
		KIND_OVERFLOW = 3'd4,
		KIND_BADESC   = 3'd5
	} sfd_kind_t;

	// one result word
	typedef struct packed {
		sfd_kind_t   kind;
		logic [7:0]  data;
		logic [15:0] length;
	} sfd_word_t;

	// one byte through the CRC-8 register, MSB first or reflected
	function automatic logic [7:0] crc8_step(input logic [7:0] crc,
			input logic [7:0] d, input logic [7:0] poly, input logic reflect);
		logic [7:0] c;
		logic [7:0] rp;
		c = crc ^ d;
		for (int i = 0; i < 8; i++) begin
			rp[i] = poly[7 - i];
		end
		for (int i = 0; i < 8; i++) begin
			if (reflect) begin
				c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
			end else begin
				c = c[7] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		return c;
	endfunction

endpackage

@@ design/stuffed_frame_deframer_crc8.sv @@
// ---------------------------------------------------------------------------
// stuffed_frame_deframer_crc8
// Byte-stuffed frame receiver with CRC-8 check; streams decoded payload.
//
//   channel   signals                         direction  word
//   input     in_valid / in_stall, rx_byte    in         one raw link byte
//   output    out_valid / out_stall,          out        one result
//             kind, data, length
//   config    cfg_wr_en, cfg_addr, cfg_data   in         one register write
//
// One byte per cycle while in_stall is low; the CRC update and byte
// classification in the front stage are combinational. A result passes
// through the queue slot (written at the accepting edge) and then the
// output register, which loads only when it is empty or being taken.
// Reset clears frame state and loads the register defaults; no sweep.
// in_stall rises only when the two-word queue is full, i.e. while the
// output side is stalled.
// ---------------------------------------------------------------------------
module stuffed_frame_deframer_crc8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  data,
	output logic [15:0] length
);
	import sfd_pkg::*;

	logic      take;
	logic      push;
	sfd_word_t push_word;
	logic      q_full;
	logic      q_not_empty;
	logic      q_pop;
	sfd_word_t q_word;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.take      (take),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_word (push_word)
	);

	sfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_word (q_word)
	);

	sfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_word      (q_word),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.data        (data),
		.length      (length)
	);

endmodule

@@ design/sfd_front.sv @@
// ---------------------------------------------------------------------------
// sfd_front
// Accepts raw bytes, undoes byte stuffing, tracks frame state and the
// running CRC, and pushes at most one result word per byte.
// ---------------------------------------------------------------------------
module sfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_addr,
	input  logic [15:0]       cfg_data,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output sfd_pkg::sfd_word_t push_word
);
	import sfd_pkg::*;

	// configuration
	logic [15:0] max_payload_q;
	logic [7:0]  crc_poly_q;
	logic [7:0]  crc_init_q;
	logic        crc_reflect_q;
	logic [7:0]  crc_xorout_q;

	// frame state
	logic                  in_frame_q, in_frame_d;
	logic                  esc_q, esc_d;
	logic                  expect_crc_q, expect_crc_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [7:0]            run_crc_q, run_crc_d;
	logic [7:0]            rx_crc_q, rx_crc_d;

	logic                  dec_valid;
	logic [7:0]            dec_byte;
	logic                  room;
	logic [COUNT_BITS-1:0] count_inc;
	logic [7:0]            crc_next;

	assign count_inc = count_q + COUNT_BITS'(1);
	assign crc_next  = crc8_step(run_crc_q, dec_byte, crc_poly_q, crc_reflect_q);
	// payload limit: configured maximum and counter saturation
	assign room = (33'(count_q) < 33'(max_payload_q)) && (count_q != '1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			crc_poly_q    <= CRC_POLY_RST;
			crc_init_q    <= CRC_INIT_RST;
			crc_reflect_q <= CRC_REFLECT_RST;
			crc_xorout_q  <= CRC_XOROUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				REG_CRC_POLY:    crc_poly_q    <= cfg_data[7:0];
				REG_CRC_INIT:    crc_init_q    <= cfg_data[7:0];
				REG_CRC_REFLECT: crc_reflect_q <= cfg_data[0];
				REG_CRC_XOROUT:  crc_xorout_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// byte classification and state update
	always_comb begin
		in_frame_d   = in_frame_q;
		esc_d        = esc_q;
		expect_crc_d = expect_crc_q;
		count_d      = count_q;
		run_crc_d    = run_crc_q;
		rx_crc_d     = rx_crc_q;
		dec_valid    = 1'b0;
		dec_byte     = rx_byte;
		push         = 1'b0;
		push_word.kind   = KIND_START;
		push_word.data   = 8'h00;
		push_word.length = 16'(count_q);

		if (!in_frame_q) begin
			// idle: only a head opens a frame
			if (rx_byte == BYTE_HEAD) begin
				in_frame_d   = 1'b1;
				esc_d        = 1'b0;
				expect_crc_d = 1'b1;
				count_d      = '0;
				run_crc_d    = crc_init_q;
				push         = 1'b1;
				push_word.length = 16'h0000;
			end
		end else if (esc_q) begin
			// byte after escape
			esc_d = 1'b0;
			unique case (rx_byte)
				ESC_CODE_HEAD: begin dec_valid = 1'b1; dec_byte = BYTE_HEAD; end
				ESC_CODE_TAIL: begin dec_valid = 1'b1; dec_byte = BYTE_TAIL; end
				ESC_CODE_ESC:  begin dec_valid = 1'b1; dec_byte = BYTE_ESC;  end
				default: begin
					in_frame_d     = 1'b0;
					push           = 1'b1;
					push_word.kind = KIND_BADESC;
				end
			endcase
		end else begin
			unique case (rx_byte)
				BYTE_HEAD: begin
					// restart
					esc_d        = 1'b0;
					expect_crc_d = 1'b1;
					count_d      = '0;
					run_crc_d    = crc_init_q;
					push         = 1'b1;
					push_word.length = 16'h0000;
				end
				BYTE_TAIL: begin
					in_frame_d = 1'b0;
					push       = 1'b1;
					push_word.kind = ((run_crc_q ^ crc_xorout_q) == rx_crc_q) ?
						KIND_GOOD : KIND_CRCERR;
				end
				BYTE_ESC: esc_d = 1'b1;
				default:  dec_valid = 1'b1;
			endcase
		end

		// decoded byte: CRC field, payload or overflow
		if (dec_valid) begin
			if (expect_crc_q) begin
				rx_crc_d     = dec_byte;
				expect_crc_d = 1'b0;
			end else if (room) begin
				count_d          = count_inc;
				run_crc_d        = crc_next;
				push             = 1'b1;
				push_word.kind   = KIND_DATA;
				push_word.data   = dec_byte;
				push_word.length = 16'(count_inc);
			end else begin
				in_frame_d     = 1'b0;
				push           = 1'b1;
				push_word.kind = KIND_OVERFLOW;
			end
		end

		if (!take) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			esc_q        <= 1'b0;
			expect_crc_q <= 1'b0;
			count_q      <= '0;
			run_crc_q    <= 8'h00;
			rx_crc_q     <= 8'h00;
		end else if (take) begin
			in_frame_q   <= in_frame_d;
			esc_q        <= esc_d;
			expect_crc_q <= expect_crc_d;
			count_q      <= count_d;
			run_crc_q    <= run_crc_d;
			rx_crc_q     <= rx_crc_d;
		end
	end

endmodule

@@ design/sfd_queue.sv @@
// ---------------------------------------------------------------------------
// sfd_queue
// Short result queue between front and back; lets each side stall alone.
// ---------------------------------------------------------------------------
module sfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sfd_pkg::sfd_word_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output sfd_pkg::sfd_word_t head_word
);
	import sfd_pkg::*;

	sfd_word_t           slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_word = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)      cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

endmodule

@@ design/sfd_back.sv @@
// ---------------------------------------------------------------------------
// sfd_back
// Output stage: pulls words from the queue into the output register and
// holds them until the consumer takes them.
// ---------------------------------------------------------------------------
module sfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  sfd_pkg::sfd_word_t q_word,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [7:0]         data,
	output logic [15:0]        length
);
	import sfd_pkg::*;

	logic      valid_q;
	sfd_word_t word_q;

	// load when the register is empty or being taken
	assign q_pop = q_not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= q_word;
		end
	end

	assign out_valid = valid_q;
	assign kind      = word_q.kind;
	assign data      = word_q.data;
	assign length    = word_q.length;

endmodule

@@ verif/stuffed_frame_deframer_crc8_tb.sv @@
// ---------------------------------------------------------------------------
// stuffed_frame_deframer_crc8_tb
// Self-checking bench for the byte-stuffed CRC-8 frame receiver. A clocked
// driver feeds raw link bytes from a queue and predicts the decoded words
// at the moment each byte is taken. A clocked monitor compares every
// result word with the oldest prediction. Phases switch the CRC settings
// and the payload limit, and random idle and stall gaps shift the timing.
// ---------------------------------------------------------------------------
module stuffed_frame_deframer_crc8_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {END_TAIL, END_NONE, END_BADESC} frame_end_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_addr = 3'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  data;
	logic [15:0] length;

	stuffed_frame_deframer_crc8 uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data(data), .length(length)
	);

	always #10 clk = ~clk;

	// shadow copy of the configuration
	logic [15:0] cfg_max = MAX_PAYLOAD_RST;
	logic [7:0]  cfg_poly = CRC_POLY_RST;
	logic [7:0]  cfg_init = CRC_INIT_RST;
	logic        cfg_reflect = CRC_REFLECT_RST;
	logic [7:0]  cfg_xorout = CRC_XOROUT_RST;

	// predicted frame state
	logic        fr_open = 1'b0;
	logic        fr_esc = 1'b0;
	logic        fr_want_crc = 1'b0;
	logic [15:0] fr_count = 16'd0;
	logic [7:0]  fr_crc = 8'd0;
	logic [7:0]  fr_rx_crc = 8'd0;

	logic [7:0]  pending_bytes [$];
	sfd_word_t   expected_words [$];
	sfd_word_t   oldest_word;

	int errors = 0;
	int items_queued = 0;
	int bytes_taken = 0;
	int words_seen = 0;
	int settings_used = 1;
	int kind_hits [0:7];
	int gap_left = 0;
	int stall_run = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	// one byte through the CRC-8 register under the current settings
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] r;
		logic [7:0] p;
		logic fb;
		int i;
		r = crc ^ d;
		p = cfg_poly;
		if (cfg_reflect) begin
			for (i = 0; i < 8; i++) begin
				p[i] = cfg_poly[7 - i];
			end
		end
		repeat (8) begin
			if (cfg_reflect) begin
				fb = r[0];
				r = {1'b0, r[7:1]};
			end else begin
				fb = r[7];
				r = {r[6:0], 1'b0};
			end
			if (fb) begin
				r = r ^ p;
			end
		end
		return r;
	endfunction

	task automatic expect_word(input sfd_kind_t k, input logic [7:0] d);
		sfd_word_t w;
		w.kind = k;
		w.data = d;
		w.length = fr_count;
		expected_words.push_back(w);
	endtask

	// decode one accepted link byte and queue the word it causes
	task automatic predict_byte(input logic [7:0] b);
		logic [7:0] dec;
		logic decoded;
		dec = b;
		decoded = 1'b0;
		if (!fr_open) begin
			if (b == BYTE_HEAD) begin
				fr_open = 1'b1;
				fr_esc = 1'b0;
				fr_want_crc = 1'b1;
				fr_count = 16'd0;
				fr_crc = cfg_init;
				expect_word(KIND_START, 8'd0);
			end
		end else if (fr_esc) begin
			fr_esc = 1'b0;
			decoded = 1'b1;
			case (b)
				ESC_CODE_HEAD: dec = BYTE_HEAD;
				ESC_CODE_TAIL: dec = BYTE_TAIL;
				ESC_CODE_ESC:  dec = BYTE_ESC;
				default: begin
					decoded = 1'b0;
					fr_open = 1'b0;
					expect_word(KIND_BADESC, 8'd0);
				end
			endcase
		end else if (b == BYTE_HEAD) begin
			fr_want_crc = 1'b1;
			fr_count = 16'd0;
			fr_crc = cfg_init;
			expect_word(KIND_START, 8'd0);
		end else if (b == BYTE_TAIL) begin
			fr_open = 1'b0;
			expect_word(((fr_crc ^ cfg_xorout) == fr_rx_crc) ? KIND_GOOD : KIND_CRCERR, 8'd0);
		end else if (b == BYTE_ESC) begin
			fr_esc = 1'b1;
		end else begin
			decoded = 1'b1;
		end

		if (decoded) begin
			if (fr_want_crc) begin
				fr_rx_crc = dec;
				fr_want_crc = 1'b0;
			end else if (fr_count < cfg_max && fr_count != '1) begin
				fr_count = fr_count + 16'd1;
				fr_crc = crc_fold(fr_crc, dec);
				expect_word(KIND_DATA, dec);
			end else begin
				fr_open = 1'b0;
				expect_word(KIND_OVERFLOW, 8'd0);
			end
		end
	endtask

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// biased toward the framing bytes and escape codes
	function automatic logic [7:0] rand_byte();
		logic [7:0] specials [0:5];
		specials = '{BYTE_HEAD, BYTE_TAIL, BYTE_ESC, ESC_CODE_HEAD, ESC_CODE_TAIL, ESC_CODE_ESC};
		if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_raw(input logic [7:0] b);
		pending_bytes.push_back(b);
		items_queued++;
	endtask

	task automatic push_stuffed(input logic [7:0] b);
		case (b)
			BYTE_HEAD: begin push_raw(BYTE_ESC); push_raw(ESC_CODE_HEAD); end
			BYTE_TAIL: begin push_raw(BYTE_ESC); push_raw(ESC_CODE_TAIL); end
			BYTE_ESC:  begin push_raw(BYTE_ESC); push_raw(ESC_CODE_ESC); end
			default:   push_raw(b);
		endcase
	endtask

	// head, CRC byte (optionally corrupted), stuffed payload, then a tail, a bad escape or no ending
	task automatic queue_frame(input int len, input logic [7:0] crc_flip, input frame_end_t how);
		logic [7:0] body [$];
		logic [7:0] crc;
		logic [7:0] b;
		int i;
		crc = cfg_init;
		for (i = 0; i < len; i++) begin
			b = rand_byte();
			body.push_back(b);
			crc = crc_fold(crc, b);
		end
		push_raw(BYTE_HEAD);
		push_stuffed(crc ^ cfg_xorout ^ crc_flip);
		for (i = 0; i < len; i++) begin
			push_stuffed(body[i]);
		end
		case (how)
			END_TAIL: push_raw(BYTE_TAIL);
			END_BADESC: begin
				push_raw(BYTE_ESC);
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == ESC_CODE_HEAD || b == ESC_CODE_TAIL || b == ESC_CODE_ESC);
				push_raw(b);
			end
			default: ;
		endcase
	endtask

	// mostly well-formed frames, some corrupted, cut short or noisy
	task automatic mix_phase(input int budget);
		int stop_at;
		int r;
		int len;
		int cap;
		stop_at = items_queued + budget;
		cap = (cfg_max < 16) ? int'(cfg_max) : 16;
		while (items_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) len = $urandom_range(0, cap + 3);
			else len = $urandom_range(0, (cap < 8) ? cap : 8);
			if (r < 60) queue_frame(len, 8'h00, END_TAIL);
			else if (r < 70) queue_frame(len, 8'($urandom_range(1, 255)), END_TAIL);
			else if (r < 78) queue_frame(len, 8'h00, END_NONE);
			else if (r < 85) queue_frame(len, 8'h00, END_BADESC);
			else if (r < 92) begin
				push_raw(BYTE_HEAD);
				push_raw(BYTE_TAIL);
			end else begin
				repeat ($urandom_range(1, 6)) push_raw(rand_byte());
			end
		end
	endtask

	// wait until every byte is taken and every word has come out
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input sfd_reg_t idx, input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		case (idx)
			REG_MAX_PAYLOAD: cfg_max = v;
			REG_CRC_POLY:    cfg_poly = v[7:0];
			REG_CRC_INIT:    cfg_init = v[7:0];
			REG_CRC_REFLECT: cfg_reflect = v[0];
			REG_CRC_XOROUT:  cfg_xorout = v[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] mx, input logic [7:0] poly,
			input logic [7:0] init, input logic refl, input logic [7:0] xo);
		write_reg(REG_MAX_PAYLOAD, mx);
		write_reg(REG_CRC_POLY, {8'd0, poly});
		write_reg(REG_CRC_INIT, {8'd0, init});
		write_reg(REG_CRC_REFLECT, {15'd0, refl});
		write_reg(REG_CRC_XOROUT, {8'd0, xo});
		settings_used++;
	endtask

	// driver: take the accepted byte, then offer the next one or a gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					rx_byte <= pending_bytes.pop_front();
					in_valid <= 1'b1;
					gap_left = next_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted word, then choose the next stall level
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				kind_hits[kind]++;
				if (expected_words.size() == 0) begin
					$error("unexpected word: kind %0d data %0h length %0d", kind, data, length);
					errors++;
				end else begin
					oldest_word = expected_words.pop_front();
					if (kind !== oldest_word.kind) begin
						$error("kind: expected %0d, actual %0d", oldest_word.kind, kind);
						errors++;
					end
					if (data !== oldest_word.data) begin
						$error("data: expected %0h, actual %0h", oldest_word.data, data);
						errors++;
					end
					if (length !== oldest_word.length) begin
						$error("length: expected %0d, actual %0d", oldest_word.length, length);
						errors++;
					end
				end
			end

			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_run > 0) begin
				stall_run--;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] directed [0:23];
		int p;
		foreach (kind_hits[k]) kind_hits[k] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: ignored bytes, tail before CRC, all escapes,
		// head after escape, restart inside a frame, unknown escape code
		directed = '{8'hAA, 8'hCC, 8'h00, 8'hFF,
			8'h55, 8'hAA,
			8'h55, 8'hCC, 8'h05, 8'h00, 8'hFF, 8'hCC, 8'h0A, 8'hCC, 8'h0C, 8'hAA,
			8'h55, 8'hCC, 8'h55,
			8'h55, 8'h12, 8'h55, 8'hCC, 8'h33};
		foreach (directed[i]) push_raw(directed[i]);
		wait_idle();

		// zero payload limit: the first payload byte of each frame overflows
		set_config(16'd0, 8'h00 | 8'h07, 8'h00, 1'b0, 8'h00);
		mix_phase(110);
		wait_idle();

		// widest limit, reflected CRC, one longer frame with no gaps
		set_config(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		quiet = 1'b1;
		queue_frame(40, 8'h00, END_TAIL);
		wait_idle();
		quiet = 1'b0;

		for (p = 0; p < 6; p++) begin
			set_config((p == 2) ? MAX_PAYLOAD_RST : 16'($urandom_range(1, 20)),
				(p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
				(p == 3) ? 8'hFF : (p == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
				p[0],
				(p == 3) ? 8'hFF : (p == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
			mix_phase(290);
			// receiver holds off while the sender keeps offering bytes
			if (p == 3) hold_req = 1'b1;
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d bytes and %0d words over %0d settings", bytes_taken,
			words_seen, settings_used);
		$display("words: start %0d data %0d good %0d crc-err %0d overflow %0d bad-esc %0d",
			kind_hits[KIND_START], kind_hits[KIND_DATA], kind_hits[KIND_GOOD],
			kind_hits[KIND_CRCERR], kind_hits[KIND_OVERFLOW], kind_hits[KIND_BADESC]);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
